[hw/rtl/prs_pkg.sv]
// ----------------------------------------------------------------------------
// prs_pkg: shared types and constants for the prime range sum block
// Holds the sequencer states, the divisor selection codes and the fixed
// constants of the 6k +/- 1 trial division.
// ----------------------------------------------------------------------------
package prs_pkg;

  // Default significant bits of each range bound
  localparam int VALUE_WIDTH_DEF = 16;

  // Result field widths
  localparam int TOTAL_W = 32;
  localparam int COUNT_W = 16;

  // Trial division constants
  localparam int TRIAL_THREE = 3;  // first odd divisor checked on its own
  localparam int TRIAL_START = 5;  // first 6k-1 divisor
  localparam int TRIAL_GAP   = 2;  // 6k-1 to 6k+1
  localparam int TRIAL_STEP  = 6;  // 6k-1 to 6(k+1)-1

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,   // wait for a transaction
    ST_PICK,   // classify the current candidate
    ST_DIV,    // bit-serial division running
    ST_EVAL,   // act on quotient and remainder
    ST_NEXT,   // accumulate and advance the candidate
    ST_DONE    // present the result for one cycle
  } state_t;

  // Which divisor the running division uses
  typedef enum logic [1:0] {
    SEL_THREE,  // divisor 3
    SEL_LOW,    // divisor d = 6k-1
    SEL_HIGH    // divisor d+2 = 6k+1
  } div_sel_t;

endpackage

[hw/rtl/prime_range_sum.sv]
// ----------------------------------------------------------------------------
// prime_range_sum: sum and count of the primes in an inclusive range
// Scans every value from low to high bound, tests each one by trial
// division over 6k +/- 1 divisors with a bit-serial restoring divider,
// and accumulates a saturating sum and a saturating count.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  input   | in_range_low, in_range_high             | start high, busy low
//  result  | out_prime_total, out_prime_count        | out_valid, one cycle
//
//  Divider: one shared restoring divider yields one quotient bit per cycle,
//  and each division is followed by the ST_EVAL evaluation state.
//  A candidate of 0..3 or an even one goes from ST_PICK straight to ST_NEXT;
//  any other runs trial divisions by 3, then by 6k-1 and 6k+1 pairs.
//  An empty range goes from idle straight to the result state.
//  Reset (synchronous, active low) returns the sequencer to idle.
//  busy stays high from acceptance through the result cycle; the receiver
//  cannot stall, so out_valid is a single-cycle strobe.
// ----------------------------------------------------------------------------
module prime_range_sum #(
  parameter int VALUE_WIDTH = prs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [VALUE_WIDTH-1:0]       in_range_low,
  input  logic [VALUE_WIDTH-1:0]       in_range_high,
  output logic                         out_valid,
  output logic [prs_pkg::TOTAL_W-1:0]  out_prime_total,
  output logic [prs_pkg::COUNT_W-1:0]  out_prime_count
);

  localparam int W     = VALUE_WIDTH;
  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam int TW    = prs_pkg::TOTAL_W;
  localparam int CW    = prs_pkg::COUNT_W;

  localparam logic [W-1:0] D_THREE = W'(prs_pkg::TRIAL_THREE);
  localparam logic [W-1:0] D_START = W'(prs_pkg::TRIAL_START);
  localparam logic [W-1:0] D_GAP   = W'(prs_pkg::TRIAL_GAP);
  localparam logic [W-1:0] D_STEP  = W'(prs_pkg::TRIAL_STEP);
  localparam logic [W-1:0] V_ONE   = W'(1);
  localparam logic [W-1:0] V_THREE = W'(3);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

  // Control state
  prs_pkg::state_t   state_r, state_nxt;

  // Payload registers
  prs_pkg::div_sel_t sel_r, sel_nxt;
  logic [W-1:0]      cand_r, cand_nxt;
  logic [W-1:0]      hi_r, hi_nxt;
  logic [W-1:0]      d_r, d_nxt;
  logic [W-1:0]      divisor_r, divisor_nxt;
  logic [W-1:0]      dvd_r, dvd_nxt;     // dividend out, quotient in
  logic [W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              prime_r, prime_nxt;
  logic [TW-1:0]     total_r, total_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  // Divider step and derived decisions
  logic [W:0]        shifted;
  logic [W:0]        diff;
  logic              fits;
  logic [TW:0]       sum_ext;
  logic              accept;
  logic              div_last;
  logic              rem_zero;
  logic              d_over_q;
  logic              cand_small;
  logic              cand_tiny;
  logic              range_empty;

  assign accept      = start && (state_r == prs_pkg::ST_IDLE);
  assign div_last    = (cnt_r == '0);
  assign rem_zero    = (rem_r == '0);
  assign d_over_q    = (d_r > dvd_r);
  assign cand_small  = (cand_r <= V_ONE);
  assign cand_tiny   = (cand_r <= V_THREE);
  assign range_empty = (in_range_low > in_range_high);

  // One restoring division step: bring down the next dividend bit
  assign shifted = {rem_r, dvd_r[W-1]};
  assign diff    = shifted - {1'b0, divisor_r};
  assign fits    = !diff[W];

  // Saturating sum of the current candidate
  assign sum_ext = {1'b0, total_r} + (TW + 1)'(cand_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prs_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = range_empty ? prs_pkg::ST_DONE : prs_pkg::ST_PICK;
        end
      end
      prs_pkg::ST_PICK: begin
        if (cand_tiny || !cand_r[0]) begin
          state_nxt = prs_pkg::ST_NEXT;
        end else begin
          state_nxt = prs_pkg::ST_DIV;
        end
      end
      prs_pkg::ST_DIV: begin
        if (div_last) begin
          state_nxt = prs_pkg::ST_EVAL;
        end
      end
      prs_pkg::ST_EVAL: begin
        case (sel_r)
          prs_pkg::SEL_THREE: begin
            state_nxt = rem_zero ? prs_pkg::ST_NEXT : prs_pkg::ST_DIV;
          end
          prs_pkg::SEL_LOW: begin
            state_nxt = (d_over_q || rem_zero) ? prs_pkg::ST_NEXT : prs_pkg::ST_DIV;
          end
          prs_pkg::SEL_HIGH: begin
            state_nxt = rem_zero ? prs_pkg::ST_NEXT : prs_pkg::ST_DIV;
          end
          default: begin
            state_nxt = prs_pkg::ST_NEXT;
          end
        endcase
      end
      prs_pkg::ST_NEXT: begin
        state_nxt = (cand_r == hi_r) ? prs_pkg::ST_DONE : prs_pkg::ST_PICK;
      end
      prs_pkg::ST_DONE: begin
        state_nxt = prs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = prs_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath next values
  always_comb begin
    busy        = (state_r != prs_pkg::ST_IDLE);
    out_valid   = (state_r == prs_pkg::ST_DONE);
    sel_nxt     = sel_r;
    cand_nxt    = cand_r;
    hi_nxt      = hi_r;
    d_nxt       = d_r;
    divisor_nxt = divisor_r;
    dvd_nxt     = dvd_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    prime_nxt   = prime_r;
    total_nxt   = total_r;
    count_nxt   = count_r;
    case (state_r)
      prs_pkg::ST_IDLE: begin
        // load the range and clear the accumulators
        if (accept) begin
          cand_nxt  = in_range_low;
          hi_nxt    = in_range_high;
          total_nxt = '0;
          count_nxt = '0;
        end
      end
      prs_pkg::ST_PICK: begin
        // settle trivial candidates, else launch the divide by three
        prime_nxt   = (!cand_small) && (cand_tiny || cand_r[0]);
        sel_nxt     = prs_pkg::SEL_THREE;
        divisor_nxt = D_THREE;
        dvd_nxt     = cand_r;
        rem_nxt     = '0;
        cnt_nxt     = CNT_LAST;
      end
      prs_pkg::ST_DIV: begin
        // shift in one quotient bit
        rem_nxt = fits ? diff[W-1:0] : shifted[W-1:0];
        dvd_nxt = {dvd_r[W-2:0], fits};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      prs_pkg::ST_EVAL: begin
        // decide, or launch the next trial division
        dvd_nxt = cand_r;
        rem_nxt = '0;
        cnt_nxt = CNT_LAST;
        case (sel_r)
          prs_pkg::SEL_THREE: begin
            prime_nxt   = 1'b0;
            d_nxt       = D_START;
            divisor_nxt = D_START;
            sel_nxt     = prs_pkg::SEL_LOW;
          end
          prs_pkg::SEL_LOW: begin
            prime_nxt   = d_over_q;
            divisor_nxt = d_r + D_GAP;
            sel_nxt     = prs_pkg::SEL_HIGH;
          end
          prs_pkg::SEL_HIGH: begin
            prime_nxt   = 1'b0;
            d_nxt       = d_r + D_STEP;
            divisor_nxt = d_r + D_STEP;
            sel_nxt     = prs_pkg::SEL_LOW;
          end
          default: begin
            prime_nxt = 1'b0;
          end
        endcase
      end
      prs_pkg::ST_NEXT: begin
        // accumulate a prime with saturation and advance
        if (prime_r) begin
          total_nxt = sum_ext[TW] ? '1 : sum_ext[TW-1:0];
          if (count_r != '1) begin
            count_nxt = count_r + CW'(1);
          end
        end
        cand_nxt = cand_r + V_ONE;
      end
      prs_pkg::ST_DONE: begin
        // hold the result on the output ports
      end
      default: begin
      end
    endcase
  end

  assign out_prime_total = total_r;
  assign out_prime_count = count_r;

  // Control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sel_r     <= sel_nxt;
    cand_r    <= cand_nxt;
    hi_r      <= hi_nxt;
    d_r       <= d_nxt;
    divisor_r <= divisor_nxt;
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    prime_r   <= prime_nxt;
    total_r   <= total_nxt;
    count_r   <= count_nxt;
  end

  // The result strobe is followed by idle
  a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("result strobe not followed by idle");

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // The divider never runs with a zero divisor
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == prs_pkg::ST_DIV) |-> (divisor_r != '0))
    else $error("division launched with zero divisor");

  // Finishing the last candidate produces the result next
  a_last_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == prs_pkg::ST_NEXT && cand_r == hi_r) |=> out_valid)
    else $error("last candidate did not produce a result");

  // An empty range reports zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && range_empty) |=> (out_valid && total_r == '0 && count_r == '0))
    else $error("empty range did not report zero");

endmodule
